// ----- hdl/frac_red_pkg.sv -----
// ----------------------------------------------------------------------------
// frac_red_pkg: shared types and constants for the fraction reducer
// Command and status bundles passed between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package frac_red_pkg;

  // Default operand width
  localparam int unsigned VALUE_BITS_DEF = 16;

  // Controller to datapath commands
  typedef struct packed {
    logic load;      // capture a new item
    logic gcd_step;  // one binary GCD step
    logic div_load;  // latch divisor, clear remainders
    logic div_step;  // one restoring division step on both quotients
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic zero;      // an operand is zero: pass through
    logic gcd_done;  // both GCD operands equal
    logic div_last;  // current division step is the last one
  } status_t;

endpackage

`default_nettype wire

// ----- hdl/frac_red_ctrl.sv -----
// ----------------------------------------------------------------------------
// frac_red_ctrl: sequencer for the fraction reducer
// Steps one item through load, GCD search, division and result strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module frac_red_ctrl (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   start,
  input  wire frac_red_pkg::status_t status,
  output frac_red_pkg::cmd_t    cmd,
  output logic                  busy,
  output logic                  done
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_GCD  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t state, state_next;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_GCD;
        end
      end
      ST_GCD: begin
        if (status.zero) begin
          state_next = ST_DONE;
        end else if (status.gcd_done) begin
          cmd.div_load = 1'b1;
          state_next   = ST_DIV;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != ST_IDLE);
  assign done = (state == ST_DONE);

endmodule

`default_nettype wire

// ----- hdl/frac_red_dp.sv -----
// ----------------------------------------------------------------------------
// frac_red_dp: datapath of the fraction reducer
// Binary GCD engine followed by two restoring dividers sharing one counter.
// ----------------------------------------------------------------------------
`default_nettype none

module frac_red_dp #(
  parameter int unsigned VALUE_BITS = frac_red_pkg::VALUE_BITS_DEF
) (
  input  wire                    clk,
  input  wire frac_red_pkg::cmd_t cmd,
  input  wire [VALUE_BITS-1:0]   numer_in,
  input  wire [VALUE_BITS-1:0]   denom_in,
  output frac_red_pkg::status_t  status,
  output logic [VALUE_BITS-1:0]  numer_out,
  output logic [VALUE_BITS-1:0]  denom_out
);

  localparam int unsigned KW = $clog2(VALUE_BITS);

  // GCD operands and common power of two
  logic [VALUE_BITS-1:0] op_a, op_b;
  logic [KW-1:0]         twos;

  // Divider state: quotients double as dividend shift registers
  logic [VALUE_BITS-1:0] quo_n, quo_d;
  logic [VALUE_BITS-1:0] rem_n, rem_d;
  logic [VALUE_BITS-1:0] divisor;
  logic [KW-1:0]         cnt;

  logic [VALUE_BITS:0]   shl_n, shl_d, dif_n, dif_d;

  // Trial subtraction for both dividers
  always_comb begin
    shl_n = {rem_n, quo_n[VALUE_BITS-1]};
    shl_d = {rem_d, quo_d[VALUE_BITS-1]};
    dif_n = shl_n - {1'b0, divisor};
    dif_d = shl_d - {1'b0, divisor};
  end

  // Binary GCD: shift out twos, subtract smaller odd from larger odd
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_a <= numer_in;
      op_b <= denom_in;
      twos <= '0;
    end else if (cmd.gcd_step) begin
      if (!op_a[0] && !op_b[0]) begin
        op_a <= op_a >> 1;
        op_b <= op_b >> 1;
        twos <= twos + KW'(1);
      end else if (!op_a[0]) begin
        op_a <= op_a >> 1;
      end else if (!op_b[0]) begin
        op_b <= op_b >> 1;
      end else if (op_a > op_b) begin
        op_a <= op_a - op_b;
      end else begin
        op_b <= op_b - op_a;
      end
    end
  end

  // Dividers: one quotient bit per cycle for each operand
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      quo_n <= numer_in;
      quo_d <= denom_in;
    end else if (cmd.div_load) begin
      divisor <= op_a << twos;
      rem_n   <= '0;
      rem_d   <= '0;
      cnt     <= KW'(VALUE_BITS - 1);
    end else if (cmd.div_step) begin
      cnt <= cnt - KW'(1);
      if (!dif_n[VALUE_BITS]) begin
        rem_n <= dif_n[VALUE_BITS-1:0];
        quo_n <= {quo_n[VALUE_BITS-2:0], 1'b1};
      end else begin
        rem_n <= shl_n[VALUE_BITS-1:0];
        quo_n <= {quo_n[VALUE_BITS-2:0], 1'b0};
      end
      if (!dif_d[VALUE_BITS]) begin
        rem_d <= dif_d[VALUE_BITS-1:0];
        quo_d <= {quo_d[VALUE_BITS-2:0], 1'b1};
      end else begin
        rem_d <= shl_d[VALUE_BITS-1:0];
        quo_d <= {quo_d[VALUE_BITS-2:0], 1'b0};
      end
    end
  end

  // Status back to the controller
  always_comb begin
    status.zero     = (op_a == '0) || (op_b == '0);
    status.gcd_done = (op_a == op_b);
    status.div_last = (cnt == '0);
  end

  assign numer_out = quo_n;
  assign denom_out = quo_d;

endmodule

`default_nettype wire

// ----- hdl/fraction_reducer.sv -----
// ----------------------------------------------------------------------------
// fraction_reducer: reduces a fraction to lowest terms
// Divides numerator and denominator by their greatest common divisor.
// ----------------------------------------------------------------------------
// Usage:
//   An item (numer_in, denom_in) is taken at a clock edge with start high and
//   busy low. busy then stays high until the result has been shown.
//   The result appears on numer_out/denom_out with done high for exactly one
//   cycle; the receiver cannot stall and must take it in that cycle.
//   If either operand is zero both values come back unchanged.
// Sequence:
//   Load, then the binary GCD loop (one step per cycle), then the divisor
//   latch, then the restoring dividers, then the result. Zero operands skip
//   straight to the result. One item is in flight at a time.
// Reset:
//   rst is synchronous; it returns the controller to idle and drops busy and
//   done. No clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module fraction_reducer #(
  parameter int unsigned VALUE_BITS = frac_red_pkg::VALUE_BITS_DEF
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   start,
  output logic                  busy,
  input  wire [VALUE_BITS-1:0]  numer_in,
  input  wire [VALUE_BITS-1:0]  denom_in,
  output logic                  done,
  output logic [VALUE_BITS-1:0] numer_out,
  output logic [VALUE_BITS-1:0] denom_out
);

  frac_red_pkg::cmd_t    cmd;
  frac_red_pkg::status_t status;

  // Sequencer
  frac_red_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  // GCD and dividers
  frac_red_dp #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk       (clk),
    .cmd       (cmd),
    .numer_in  (numer_in),
    .denom_in  (denom_in),
    .status    (status),
    .numer_out (numer_out),
    .denom_out (denom_out)
  );

  // Result strobe only while an item is in flight
  assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("done without busy");

  // Result strobe lasts one cycle and frees the block
  assert property (@(posedge clk) disable iff (rst) done |=> !done && !busy)
    else $error("done held or block stuck busy");

  // Accepted item makes the block busy
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy && !done)
    else $error("accepted item did not start work");

endmodule

`default_nettype wire
